@@ rtl/otq_pkg.sv @@
// Shared types and codes for the ordered timer queue.
`default_nettype none
package otq_pkg;
	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_TICK   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		EV_ADDED   = 2'd0,
		EV_FULL    = 2'd1,
		EV_REMOVED = 2'd2,
		EV_FIRED   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_EMIT
	} state_t;
endpackage
`default_nettype wire

@@ rtl/otq_cmd_fifo.sv @@
// Command queue between the front end and the timer engine.
`default_nettype none
module otq_cmd_fifo #(
	parameter int WIDTH = 59,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ rtl/otq_engine.sv @@
// Timer table and sequencer: add, remove and tick with ordered firing.
`default_nettype none
module otq_engine #(
	parameter int SLOTS      = 16,
	parameter int TIME_BITS  = 48,
	parameter int DELAY_BITS = 24,
	parameter int ID_BITS    = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire otq_pkg::func_t        cmd_func,
	input  wire logic [DELAY_BITS-1:0] cmd_delay,
	input  wire logic                  cmd_repeat,
	input  wire logic [ID_BITS-1:0]    cmd_id,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 event_res,
	output logic [31:0]                task_id_res,
	output logic [31:0]                rearm_id,
	output logic                       found,
	output logic                       last
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	otq_pkg::state_t state_q, state_d;
	logic [TIME_BITS-1:0]  now_q;
	logic [ID_BITS-1:0]    idc_q;
	logic [SLOTS-1:0]      valid_q, done_q;
	logic [TIME_BITS-1:0]  exp_q [SLOTS];
	logic [ID_BITS-1:0]    ident_q [SLOTS];
	logic                  per_q [SLOTS];
	logic [DELAY_BITS-1:0] prd_q [SLOTS];

	otq_pkg::func_t        func_q;
	logic [DELAY_BITS-1:0] delay_q;
	logic                  rep_q;
	logic [ID_BITS-1:0]    tid_q;
	logic [CW-1:0]         idx_q;
	logic                  have_q;
	logic [SW-1:0]         best_q;
	logic                  any_q;

	logic                  ov_q;
	logic [1:0]            ev_q;
	logic [31:0]           oid_q, orearm_q;
	logic                  ofnd_q, olast_q;

	logic [SW-1:0] idx_s;
	logic [ID_BITS-1:0] nid;
	logic cand, better;

	assign idx_s = idx_q[SW-1:0];
	assign nid = (idc_q + 1'b1 == '0) ? ID_BITS'(1) : idc_q + 1'b1;
	assign cand = valid_q[idx_s] && !done_q[idx_s] && (exp_q[idx_s] <= now_q);
	assign better = !have_q || (exp_q[idx_s] < exp_q[best_q]) ||
		(exp_q[idx_s] == exp_q[best_q] && ident_q[idx_s] < ident_q[best_q]);

	assign cmd_ready = (state_q == otq_pkg::ST_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign event_res = ev_q;
	assign task_id_res = oid_q;
	assign rearm_id = orearm_q;
	assign found = ofnd_q;
	assign last = olast_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			otq_pkg::ST_IDLE:
				if (cmd_valid && cmd_ready && cmd_func != otq_pkg::FUNC_NONE)
					state_d = otq_pkg::ST_SCAN;
			otq_pkg::ST_SCAN:
				if (idx_q == CW'(SLOTS)) state_d = otq_pkg::ST_FIRE;
			otq_pkg::ST_FIRE: state_d = otq_pkg::ST_EMIT;
			otq_pkg::ST_EMIT:
				if (!ov_q) begin
					if (func_q == otq_pkg::FUNC_TICK && any_q) state_d = otq_pkg::ST_SCAN;
					else state_d = otq_pkg::ST_IDLE;
				end
			default: state_d = otq_pkg::ST_IDLE;
		endcase
	end

	// Slot payload, command fields and output registers: no reset.
	always_ff @(posedge clk) begin
		if (state_q == otq_pkg::ST_FIRE && func_q == otq_pkg::FUNC_ADD && have_q) begin
			exp_q[best_q] <= now_q + TIME_BITS'(delay_q);
			ident_q[best_q] <= nid;
			per_q[best_q] <= rep_q;
			prd_q[best_q] <= (delay_q == '0) ? DELAY_BITS'(1) : delay_q;
		end
		if (state_q == otq_pkg::ST_FIRE && func_q == otq_pkg::FUNC_TICK && have_q &&
			per_q[best_q]) begin
			ident_q[best_q] <= nid;
			exp_q[best_q] <= now_q + TIME_BITS'(prd_q[best_q]);
		end
		if (state_q == otq_pkg::ST_IDLE && cmd_valid && cmd_ready) begin
			delay_q <= cmd_delay;
			rep_q <= cmd_repeat;
			tid_q <= cmd_id;
		end
		if (state_q == otq_pkg::ST_FIRE) begin
			oid_q <= '0;
			orearm_q <= '0;
			ofnd_q <= 1'b0;
			olast_q <= 1'b1;
			ev_q <= otq_pkg::EV_ADDED;
			case (func_q)
				otq_pkg::FUNC_ADD: begin
					ev_q <= have_q ? otq_pkg::EV_ADDED : otq_pkg::EV_FULL;
					if (have_q) oid_q <= 32'(nid);
				end
				otq_pkg::FUNC_REMOVE: begin
					ev_q <= otq_pkg::EV_REMOVED;
					oid_q <= 32'(tid_q);
					ofnd_q <= have_q;
				end
				otq_pkg::FUNC_TICK: begin
					ev_q <= otq_pkg::EV_FIRED;
					oid_q <= 32'(ident_q[best_q]);
					if (per_q[best_q]) orearm_q <= 32'(nid);
					olast_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (state_q == otq_pkg::ST_SCAN && idx_q == CW'(SLOTS) &&
			func_q == otq_pkg::FUNC_TICK && have_q)
			olast_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otq_pkg::ST_IDLE;
			now_q <= '0;
			idc_q <= '0;
			valid_q <= '0;
			done_q <= '0;
			func_q <= otq_pkg::FUNC_NONE;
			idx_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			any_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				otq_pkg::ST_IDLE:
					if (cmd_valid && cmd_ready && cmd_func != otq_pkg::FUNC_NONE) begin
						func_q <= cmd_func;
						idx_q <= '0;
						have_q <= 1'b0;
						best_q <= '0;
						any_q <= 1'b0;
						done_q <= '0;
						if (cmd_func == otq_pkg::FUNC_TICK) now_q <= now_q + 1'b1;
					end
				otq_pkg::ST_SCAN:
					if (idx_q != CW'(SLOTS)) begin
						idx_q <= idx_q + 1'b1;
						case (func_q)
							otq_pkg::FUNC_ADD:
								if (!have_q && !valid_q[idx_s]) begin
									have_q <= 1'b1;
									best_q <= idx_s;
								end
							otq_pkg::FUNC_REMOVE:
								if (!have_q && valid_q[idx_s] && ident_q[idx_s] == tid_q) begin
									have_q <= 1'b1;
									best_q <= idx_s;
								end
							otq_pkg::FUNC_TICK:
								if (cand && better) begin
									have_q <= 1'b1;
									best_q <= idx_s;
								end
							default: ;
						endcase
					end
				otq_pkg::ST_FIRE: begin
					case (func_q)
						otq_pkg::FUNC_ADD: begin
							ov_q <= 1'b1;
							if (have_q) begin
								valid_q[best_q] <= 1'b1;
								idc_q <= nid;
							end
						end
						otq_pkg::FUNC_REMOVE: begin
							ov_q <= 1'b1;
							if (have_q) valid_q[best_q] <= 1'b0;
						end
						otq_pkg::FUNC_TICK:
							if (have_q) begin
								done_q[best_q] <= 1'b1;
								any_q <= 1'b1;
								ov_q <= 1'b1;
								if (per_q[best_q]) idc_q <= nid;
								else valid_q[best_q] <= 1'b0;
							end
						default: ;
					endcase
				end
				otq_pkg::ST_EMIT:
					// hold the fired item until taken, then look for the next one
					if (func_q == otq_pkg::FUNC_TICK && any_q && !ov_q) begin
						idx_q <= '0;
						have_q <= 1'b0;
						any_q <= 1'b0;
					end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/ordered_timer_queue_top.sv @@
// Top level of the ordered timer queue.
// One item at a time. The engine takes an item while idle, then scans all slots, fires
// and emits; an add or remove keeps it busy until its result has been passed on.
// A tick takes one scan per fired timer plus one final empty scan. A fired timer is
// delivered before the next scan, and its last flag is set on the item found by the
// final scan to be the end: so each fired item waits for one lookahead scan. Output
// stalls stretch each of these. Items enter through a two-entry queue.
`default_nettype none
module ordered_timer_queue_top #(
	parameter int SLOTS      = 16,
	parameter int TIME_BITS  = 48,
	parameter int DELAY_BITS = 24,
	parameter int ID_BITS    = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            func,
	input  wire logic [DELAY_BITS-1:0] delay,
	input  wire logic                  repeat_req,
	input  wire logic [31:0]           task_id,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 event_res,
	output logic [31:0]                task_id_res,
	output logic [31:0]                rearm_id,
	output logic                       found,
	output logic                       last
);
	localparam int QW = 2 + DELAY_BITS + 1 + ID_BITS;
	logic [QW-1:0] q_in, q_out;
	logic q_valid, q_ready;
	logic pv;
	logic [1:0] pev;
	logic [31:0] pid, prearm;
	logic pfnd, plast;
	logic hold_q;
	logic [1:0] hev_q;
	logic [31:0] hid_q, hrearm_q;
	logic hfnd_q;
	logic ready_fire, pend_last_q;

	assign q_in = {func, delay, repeat_req, ID_BITS'(task_id)};

	otq_cmd_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
		.clk, .arst_n,
		.in_valid(in_valid), .in_ready(in_ready), .in_data(q_in),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_out)
	);

	logic eng_ready;
	otq_engine #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .DELAY_BITS(DELAY_BITS),
		.ID_BITS(ID_BITS)) u_eng (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(eng_ready),
		.cmd_func(otq_pkg::func_t'(q_out[QW-1 -: 2])),
		.cmd_delay(q_out[ID_BITS+1 +: DELAY_BITS]),
		.cmd_repeat(q_out[ID_BITS]),
		.cmd_id(q_out[ID_BITS-1:0]),
		.out_valid(pv), .out_ready(!hold_q || ready_fire),
		.event_res(pev), .task_id_res(pid), .rearm_id(prearm),
		.found(pfnd), .last(plast)
	);
	assign q_ready = eng_ready;

	// Hold a fired item until the next scan tells whether it was the last.
	logic take;
	assign take = pv && (!hold_q || ready_fire);
	assign out_valid = hold_q && (pend_last_q || (pv && !pend_last_q));
	assign ready_fire = out_valid && out_ready;
	assign event_res = hev_q;
	assign task_id_res = hid_q;
	assign rearm_id = hrearm_q;
	assign found = hfnd_q;
	assign last = pend_last_q;

	// pend_last_q: held item is final.
	logic eng_idle_seen;
	assign eng_idle_seen = eng_ready && !pv;

	always_ff @(posedge clk) begin
		if (take) begin
			hev_q <= pev;
			hid_q <= pid;
			hrearm_q <= prearm;
			hfnd_q <= pfnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (take) begin
				hold_q <= 1'b1;
				pend_last_q <= plast;
			end else if (ready_fire) begin
				hold_q <= 1'b0;
				pend_last_q <= 1'b0;
			end else if (hold_q && eng_idle_seen) begin
				pend_last_q <= 1'b1;
			end
		end
	end

	a_last_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hold_q) else $error("result shown without held item");
	a_fire_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == otq_pkg::EV_FIRED) |-> task_id_res != '0)
		else $error("fired id is zero");
	a_remove_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res != otq_pkg::EV_FIRED) |-> rearm_id == '0)
		else $error("rearm id on non-fire item");
endmodule
`default_nettype wire

@@ tb/sv/ordered_timer_queue_top_test.sv @@
// Self-checking testbench for the ordered timer queue: add, remove and tick items.
`default_nettype none
module ordered_timer_queue_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int TB = 48;
	localparam int MAXM = 10;

	typedef struct packed {
		otq_pkg::event_t ev;
		logic [31:0]     id;
		logic [31:0]     rearm;
		logic            fnd;
		logic            lst;
	} timer_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = otq_pkg::FUNC_ADD;
	logic [23:0] delay = '0;
	logic repeat_req = 1'b0;
	logic [31:0] task_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] event_res;
	logic [31:0] task_id_res;
	logic [31:0] rearm_id;
	logic found;
	logic last;

	ordered_timer_queue_top uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .delay(delay), .repeat_req(repeat_req), .task_id(task_id),
		.out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
		.task_id_res(task_id_res), .rearm_id(rearm_id), .found(found), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [TB-1:0] clock_ms;
	logic [31:0]   last_id;
	logic          live [SLOTS];
	logic [TB-1:0] due [SLOTS];
	logic [31:0]   ident [SLOTS];
	logic          periodic [SLOTS];
	logic [23:0]   period [SLOTS];

	timer_event_t pending_events[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;

	function automatic logic [31:0] issue_id();
		last_id = last_id + 32'd1;
		if (last_id == 32'd0)
			last_id = 32'd1;
		return last_id;
	endfunction

	function automatic timer_event_t mk(otq_pkg::event_t e, logic [31:0] i, logic [31:0] r,
			logic f, logic l);
		timer_event_t t;
		t.ev = e; t.id = i; t.rearm = r; t.fnd = f; t.lst = l;
		return t;
	endfunction

	task automatic predict_timer(logic [1:0] f, logic [23:0] d, logic rp, logic [31:0] tid);
		int slot;
		int best;
		logic done [SLOTS];
		logic [31:0] rid;
		int n;
		slot = -1;
		n = 0;
		if (f == otq_pkg::FUNC_ADD) begin
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!live[i]) slot = i;
			if (slot < 0) begin
				pending_events.push_back(mk(otq_pkg::EV_FULL, 0, 0, 0, 1));
			end else begin
				live[slot] = 1'b1;
				due[slot] = clock_ms + TB'(d);
				ident[slot] = issue_id();
				periodic[slot] = rp;
				period[slot] = (d == 0) ? 24'd1 : d;
				pending_events.push_back(mk(otq_pkg::EV_ADDED, ident[slot], 0, 0, 1));
			end
		end else if (f == otq_pkg::FUNC_REMOVE) begin
			for (int i = SLOTS - 1; i >= 0; i--)
				if (live[i] && ident[i] == tid) slot = i;
			if (slot >= 0) live[slot] = 1'b0;
			pending_events.push_back(mk(otq_pkg::EV_REMOVED, tid, 0, slot >= 0, 1));
		end else if (f == otq_pkg::FUNC_TICK) begin
			clock_ms = clock_ms + 1;
			for (int i = 0; i < SLOTS; i++) done[i] = 1'b0;
			forever begin
				best = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!live[i] || done[i] || due[i] > clock_ms) continue;
					if (best < 0 || due[i] < due[best] ||
							(due[i] == due[best] && ident[i] < ident[best]))
						best = i;
				end
				if (best < 0) break;
				done[best] = 1'b1;
				rid = 0;
				tid = ident[best];
				if (periodic[best]) begin
					rid = issue_id();
					ident[best] = rid;
					due[best] = clock_ms + TB'(period[best]);
				end else begin
					live[best] = 1'b0;
				end
				pending_events.push_back(mk(otq_pkg::EV_FIRED, tid, rid, 0, 0));
				n++;
			end
			if (n > 0) pending_events[$].lst = 1'b1;
		end
	endtask

	// valid stays up after an accept until the next item, an idle cycle or a drain drops it
	task automatic send_item(logic [1:0] f, logic [23:0] d, logic rp, logic [31:0] tid);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		delay <= d;
		repeat_req <= rp;
		task_id <= tid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_timer(f, d, rp, tid);
	endtask

	// receiver with random stalls and the result check
	always @(posedge clk) begin
		timer_event_t want;
		if (out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= MAXM)
					$display("unexpected item ev=%0d id=%0h", event_res, task_id_res);
			end else begin
				want = pending_events.pop_front();
				if (event_res !== want.ev || task_id_res !== want.id ||
						rearm_id !== want.rearm || found !== want.fnd || last !== want.lst) begin
					errors++;
					if (errors <= MAXM) begin
						$display("mismatch exp ev=%0d id=%0h re=%0h f=%0b l=%0b",
							want.ev, want.id, want.rearm, want.fnd, want.lst);
						$display("         got ev=%0d id=%0h re=%0h f=%0b l=%0b",
							event_res, task_id_res, rearm_id, found, last);
					end
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic drain_events();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SLOTS * 8) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(otq_pkg::FUNC_ADD, 24'd0, 1'b1, 0);          // zero period
		send_item(otq_pkg::FUNC_ADD, 24'hFFFFFF, 1'b0, 0);
		send_item(otq_pkg::FUNC_ADD, 24'd2, 1'b0, 0);
		send_item(otq_pkg::FUNC_ADD, 24'd2, 1'b1, 0);
		send_item(otq_pkg::FUNC_NONE, 24'hFFFFFF, 1'b1, '1);    // ignored
		send_item(otq_pkg::FUNC_TICK, 0, 0, 0);
		send_item(otq_pkg::FUNC_TICK, '1, 1, '1);
		send_item(otq_pkg::FUNC_REMOVE, 0, 0, 32'd2);
		send_item(otq_pkg::FUNC_REMOVE, '1, 1, 32'hFFFFFFFF);  // miss
		send_item(otq_pkg::FUNC_REMOVE, 0, 0, 32'd2);          // miss again
		drain_events();
	endtask

	task automatic test_full_table();
		for (int i = 0; i < SLOTS + 2; i++)
			send_item(otq_pkg::FUNC_ADD, 24'd3 + 24'(i % 2), 1'($urandom), $urandom);
		for (int i = 0; i < 5; i++) send_item(otq_pkg::FUNC_TICK, 0, 0, 0);
		drain_events();
	endtask

	task automatic test_random(int count);
		int r;
		logic [31:0] tid;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			tid = (last_id > 4) ? last_id - $urandom_range(4) : $urandom_range(4);
			if ($urandom_range(9) == 0) tid = $urandom;
			if (r < 40)
				send_item(otq_pkg::FUNC_ADD, ($urandom_range(7) == 0) ? 24'($urandom) :
					24'($urandom_range(6)), 1'($urandom), $urandom);
			else if (r < 55)
				send_item(otq_pkg::FUNC_REMOVE, 24'($urandom), 1'($urandom), tid);
			else if (r < 97)
				send_item(otq_pkg::FUNC_TICK, 24'($urandom), 1'($urandom), $urandom);
			else
				send_item(otq_pkg::FUNC_NONE, 24'($urandom), 1'($urandom), $urandom);
		end
		// hold until every expected result is in
		drain_events();
	endtask

	initial begin
		clock_ms = '0;
		last_id = '0;
		for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 24; recv_idle = 49;
		test_directed();
		test_full_table();
		test_random(25);
		send_idle = 49; recv_idle = 24;
		test_random(25);
		send_idle = 0; recv_idle = 0;
		test_random(25);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

@@ ordered_timer_queue_top.f @@
rtl/otq_pkg.sv
rtl/otq_cmd_fifo.sv
rtl/otq_engine.sv
rtl/ordered_timer_queue_top.sv
tb/sv/ordered_timer_queue_top_test.sv
